// File: src/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg - shared definitions for the quadratic root solver
// Default widths, root field width and the solution kind codes.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int COEF_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int ROOT_BITS     = 34;

   typedef enum logic [2:0] {
      KIND_INFINITE = 3'd0,
      KIND_NONE     = 3'd1,
      KIND_LINEAR   = 3'd2,
      KIND_TWO      = 3'd3,
      KIND_DOUBLE   = 3'd4,
      KIND_COMPLEX  = 3'd5
   } kind_type;

endpackage

// File: src/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt - pipelined floor square root
// One root bit per stage, two radicand bits consumed per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
   parameter int RAD_W  = 34,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int STAGES = RAD_W / 2;
   localparam int REM_W  = STAGES + 2;

   logic              vld_ff  [STAGES];
   logic [RAD_W-1:0]  rad_ff  [STAGES];
   logic [REM_W-1:0]  rem_ff  [STAGES];
   logic [STAGES-1:0] root_ff [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic              v_cur;
      logic [RAD_W-1:0]  rad_cur;
      logic [REM_W-1:0]  rem_cur;
      logic [STAGES-1:0] root_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [REM_W-1:0]  rem_cat;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [STAGES-1:0] root_in;

      if (i == 0) begin : g_src
         assign v_cur    = in_valid;
         assign rad_cur  = in_rad;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign side_cur = in_side;
      end else begin : g_src
         assign v_cur    = vld_ff[i-1];
         assign rad_cur  = rad_ff[i-1];
         assign rem_cur  = rem_ff[i-1];
         assign root_cur = root_ff[i-1];
         assign side_cur = side_ff[i-1];
      end

      always_comb begin
         rem_cat = {rem_cur[REM_W-3:0], rad_cur[RAD_W-1 -: 2]};
         trial   = {root_cur, 2'b01};
         if (rem_cat >= trial) begin
            rem_in  = rem_cat - trial;
            root_in = {root_cur[STAGES-2:0], 1'b1};
         end else begin
            rem_in  = rem_cat;
            root_in = {root_cur[STAGES-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= v_cur;
         end
         rad_ff[i]  <= {rad_cur[RAD_W-3:0], 2'b00};
         rem_ff[i]  <= rem_in;
         root_ff[i] <= root_in;
         side_ff[i] <= side_cur;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

// File: src/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div - pipelined unsigned restoring divider
// One quotient bit per stage, msb first.
// ----------------------------------------------------------------------------
module qrs_div #(
   parameter int NUM_W  = 34,
   parameter int DEN_W  = 17,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [NUM_W-1:0]     in_num,
   input  logic [DEN_W-1:0]     in_den,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [NUM_W-1:0]     out_quot,
   output logic [SIDE_W-1:0]    out_side
);

   logic              vld_ff  [NUM_W];
   logic [NUM_W-1:0]  num_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  quot_ff [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic              v_cur;
      logic [NUM_W-1:0]  num_cur;
      logic [DEN_W-1:0]  den_cur;
      logic [DEN_W-1:0]  rem_cur;
      logic [NUM_W-1:0]  quot_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [DEN_W:0]    rem_cat;
      logic [DEN_W:0]    rem_sub;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  quot_in;

      if (i == 0) begin : g_src
         assign v_cur    = in_valid;
         assign num_cur  = in_num;
         assign den_cur  = in_den;
         assign rem_cur  = '0;
         assign quot_cur = '0;
         assign side_cur = in_side;
      end else begin : g_src
         assign v_cur    = vld_ff[i-1];
         assign num_cur  = num_ff[i-1];
         assign den_cur  = den_ff[i-1];
         assign rem_cur  = rem_ff[i-1];
         assign quot_cur = quot_ff[i-1];
         assign side_cur = side_ff[i-1];
      end

      always_comb begin
         rem_cat = {rem_cur, num_cur[NUM_W-1]};
         rem_sub = rem_cat - {1'b0, den_cur};
         if (rem_cat >= {1'b0, den_cur}) begin
            rem_in  = rem_sub[DEN_W-1:0];
            quot_in = {quot_cur[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_cat[DEN_W-1:0];
            quot_in = {quot_cur[NUM_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= v_cur;
         end
         num_ff[i]  <= {num_cur[NUM_W-2:0], 1'b0};
         den_ff[i]  <= den_cur;
         rem_ff[i]  <= rem_in;
         quot_ff[i] <= quot_in;
         side_ff[i] <= side_cur;
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quot  = quot_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// File: src/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver - real roots of a*x^2 + b*x + c = 0
// Fully pipelined: products, discriminant, floor square root, fixed point
// divides and saturation, one coefficient set per clock.
// ----------------------------------------------------------------------------
//
//  channel   ports                                  handshake
//  -------   -------------------------------------  ------------------------
//  request   req_coef_quad, req_coef_lin,           start high, busy low
//            req_coef_const
//  response  rsp_solution_kind, rsp_root_one,       rsp_valid, one cycle
//            rsp_root_two
//
//  - a new beat may be started on every clock; busy is never raised
//  - the pipe runs through stage 1, stage 2, the COEF_BITS+1 square root stages,
//    stage 3, the COEF_BITS+FRAC_BITS+2 divide stages and stage 4
//  - synchronous reset clears the valid bits only; data registers are free
//  - the receiver cannot stall, so every result beat leaves on its strobe
//
module quadratic_root_solver #(
   parameter int COEF_BITS = qrs_pkg::COEF_BITS_DEF,
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [COEF_BITS-1:0]       req_coef_quad,
   input  logic signed [COEF_BITS-1:0]       req_coef_lin,
   input  logic signed [COEF_BITS-1:0]       req_coef_const,
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_solution_kind,
   output logic signed [qrs_pkg::ROOT_BITS-1:0] rsp_root_one,
   output logic signed [qrs_pkg::ROOT_BITS-1:0] rsp_root_two
);

   localparam int RB      = qrs_pkg::ROOT_BITS;
   localparam int PROD_W  = 2 * COEF_BITS;
   localparam int RAD_W   = 2 * COEF_BITS + 2;     // signed discriminant width
   localparam int SQ_W    = RAD_W / 2;             // square root width
   localparam int NUMS_W  = COEF_BITS + 3;         // signed numerator width
   localparam int NMAG_W  = COEF_BITS + 2;         // numerator magnitude
   localparam int NUM_W   = NMAG_W + FRAC_BITS;    // shifted dividend
   localparam int DEN_W   = COEF_BITS + 1;         // divisor magnitude
   localparam int DS_W    = COEF_BITS + 2;         // signed divisor
   localparam int SIDE1_W = 3 + 3 * COEF_BITS;
   localparam int QX_W    = ((NUM_W > RB) ? NUM_W : RB) + 1;
   localparam logic [QX_W-1:0] LIM = QX_W'(1) << (RB - 1);

   // no stall anywhere in the pipe
   assign busy = 1'b0;

   // ---- stage 1: register coefficients and the two products
   logic                       v1_ff;
   logic signed [COEF_BITS-1:0] a1_ff, b1_ff, c1_ff;
   logic signed [PROD_W-1:0]   bb1_ff, ac1_ff;
   logic signed [PROD_W-1:0]   bb1_in, ac1_in;

   assign bb1_in = PROD_W'(req_coef_lin) * PROD_W'(req_coef_lin);
   assign ac1_in = PROD_W'(req_coef_quad) * PROD_W'(req_coef_const);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
      end
      a1_ff  <= req_coef_quad;
      b1_ff  <= req_coef_lin;
      c1_ff  <= req_coef_const;
      bb1_ff <= bb1_in;
      ac1_ff <= ac1_in;
   end

   // ---- stage 2: discriminant and case decision
   logic signed [RAD_W-1:0] disc;
   qrs_pkg::kind_type       kind2_in;
   logic                    v2_ff;
   logic [RAD_W-1:0]        rad2_ff, rad2_in;
   logic [SIDE1_W-1:0]      side2_ff;

   always_comb begin
      disc = RAD_W'(bb1_ff) - (RAD_W'(ac1_ff) <<< 2);
      if (a1_ff == '0 && b1_ff == '0) begin
         kind2_in = (c1_ff == '0) ? qrs_pkg::KIND_INFINITE : qrs_pkg::KIND_NONE;
      end else if (a1_ff == '0) begin
         kind2_in = qrs_pkg::KIND_LINEAR;
      end else if (disc[RAD_W-1]) begin
         kind2_in = qrs_pkg::KIND_COMPLEX;
      end else if (disc == '0) begin
         kind2_in = qrs_pkg::KIND_DOUBLE;
      end else begin
         kind2_in = qrs_pkg::KIND_TWO;
      end
      // only a positive discriminant feeds the root
      rad2_in = disc[RAD_W-1] ? '0 : disc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      rad2_ff  <= rad2_in;
      side2_ff <= {kind2_in, a1_ff, b1_ff, c1_ff};
   end

   // ---- square root pipeline
   logic               sq_valid;
   logic [SQ_W-1:0]    sq_root;
   logic [SIDE1_W-1:0] sq_side;

   qrs_sqrt #(
      .RAD_W  (RAD_W),
      .SIDE_W (SIDE1_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_rad    (rad2_ff),
      .in_side   (side2_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ---- stage 3: numerators, divisor, signs
   qrs_pkg::kind_type           kind3;
   logic signed [COEF_BITS-1:0] a3, b3, c3;
   logic signed [NUMS_W-1:0]    sv, nb, n1, n2;
   logic signed [DS_W-1:0]      den_s;
   logic [NUMS_W-1:0]           m1, m2;
   logic [DS_W-1:0]             md;
   logic                        v3_ff, neg1_in, neg2_in, neg1_ff, neg2_ff;
   logic [NUM_W-1:0]            num1_ff, num2_ff;
   logic [DEN_W-1:0]            den3_ff;
   logic [2:0]                  kind3_ff;

   always_comb begin
      kind3 = qrs_pkg::kind_type'(sq_side[SIDE1_W-1 -: 3]);
      a3    = sq_side[3*COEF_BITS-1 -: COEF_BITS];
      b3    = sq_side[2*COEF_BITS-1 -: COEF_BITS];
      c3    = sq_side[COEF_BITS-1:0];
      sv    = NUMS_W'(sq_root);
      nb    = -NUMS_W'(b3);
      if (kind3 == qrs_pkg::KIND_LINEAR) begin
         n1    = -NUMS_W'(c3);
         den_s = DS_W'(b3);
      end else begin
         n1    = nb + sv;
         den_s = DS_W'(a3) <<< 1;
      end
      n2      = nb - sv;
      m1      = n1[NUMS_W-1] ? -n1 : n1;
      m2      = n2[NUMS_W-1] ? -n2 : n2;
      md      = den_s[DS_W-1] ? -den_s : den_s;
      neg1_in = n1[NUMS_W-1] ^ den_s[DS_W-1];
      neg2_in = n2[NUMS_W-1] ^ den_s[DS_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= sq_valid;
      end
      num1_ff  <= {m1[NMAG_W-1:0], {FRAC_BITS{1'b0}}};
      num2_ff  <= {m2[NMAG_W-1:0], {FRAC_BITS{1'b0}}};
      den3_ff  <= md[DEN_W-1:0];
      neg1_ff  <= neg1_in;
      neg2_ff  <= neg2_in;
      kind3_ff <= kind3;
   end

   // ---- two divide pipelines sharing the divisor
   logic             d1_valid, d2_valid;
   logic [NUM_W-1:0] q1, q2;
   logic [3:0]       d1_side;
   logic             d2_side;

   qrs_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (DEN_W),
      .SIDE_W (4)
   ) u_div_one (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_num    (num1_ff),
      .in_den    (den3_ff),
      .in_side   ({kind3_ff, neg1_ff}),
      .out_valid (d1_valid),
      .out_quot  (q1),
      .out_side  (d1_side)
   );

   qrs_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (DEN_W),
      .SIDE_W (1)
   ) u_div_two (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_num    (num2_ff),
      .in_den    (den3_ff),
      .in_side   (neg2_ff),
      .out_valid (d2_valid),
      .out_quot  (q2),
      .out_side  (d2_side)
   );

   // ---- stage 4: sign, saturation, masking of unused fields
   qrs_pkg::kind_type kind4;
   logic [QX_W-1:0]   qx1, qx2, r1x, r2x;
   logic [RB-1:0]     r1_in, r2_in;
   logic              vo_ff;
   logic [2:0]        kind_ff;
   logic [RB-1:0]     r1_ff, r2_ff;

   always_comb begin
      kind4 = qrs_pkg::kind_type'(d1_side[3:1]);
      qx1   = QX_W'(q1);
      qx2   = QX_W'(q2);
      if (d1_side[0]) begin
         r1x = (qx1 >= LIM) ? -LIM : -qx1;
      end else begin
         r1x = (qx1 >= LIM) ? (LIM - QX_W'(1)) : qx1;
      end
      if (d2_side) begin
         r2x = (qx2 >= LIM) ? -LIM : -qx2;
      end else begin
         r2x = (qx2 >= LIM) ? (LIM - QX_W'(1)) : qx2;
      end
      r1_in = '0;
      r2_in = '0;
      case (kind4) inside
         qrs_pkg::KIND_LINEAR: begin
            r1_in = r1x[RB-1:0];
         end
         qrs_pkg::KIND_TWO, qrs_pkg::KIND_DOUBLE: begin
            r1_in = r1x[RB-1:0];
            r2_in = r2x[RB-1:0];
         end
         default: begin
            r1_in = '0;
            r2_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= d1_valid & d2_valid;
      end
      kind_ff <= kind4;
      r1_ff   <= r1_in;
      r2_ff   <= r2_in;
   end

   assign rsp_valid         = vo_ff;
   assign rsp_solution_kind = kind_ff;
   assign rsp_root_one      = r1_ff;
   assign rsp_root_two      = r2_ff;

endmodule

// File: src/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_checker - port level checks for the quadratic root solver
// Latency, kind range, unused root fields and equal double roots.
// ----------------------------------------------------------------------------
module qrs_checker #(
   parameter int LATENCY   = 55
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [2:0]                     rsp_solution_kind,
   input logic [qrs_pkg::ROOT_BITS-1:0]  rsp_root_one,
   input logic [qrs_pkg::ROOT_BITS-1:0]  rsp_root_two
);

   // a result beat only ever follows an accepted request by the pipe depth
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result beat without matching request");

   a_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_solution_kind <= qrs_pkg::KIND_COMPLEX))
      else $error("solution kind out of range");

   a_unused : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_solution_kind == qrs_pkg::KIND_INFINITE
         || rsp_solution_kind == qrs_pkg::KIND_NONE
         || rsp_solution_kind == qrs_pkg::KIND_COMPLEX))
      |-> (rsp_root_one == '0 && rsp_root_two == '0))
      else $error("root fields not zero");

   a_linear : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_solution_kind == qrs_pkg::KIND_LINEAR)
      |-> (rsp_root_two == '0))
      else $error("second root not zero on linear case");

   a_double : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_solution_kind == qrs_pkg::KIND_DOUBLE)
      |-> (rsp_root_one == rsp_root_two))
      else $error("double root fields differ");

endmodule

bind quadratic_root_solver qrs_checker #(
   .LATENCY   (2 * COEF_BITS + FRAC_BITS + 7)
) u_qrs_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_solution_kind (rsp_solution_kind),
   .rsp_root_one      (rsp_root_one),
   .rsp_root_two      (rsp_root_two)
);

// File: tb/quadratic_root_solver_test.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_test - self-checking bench for the root solver
// Drives coefficient sets through the command port, predicts the case code
// and both fixed point roots for each accepted beat, and checks every result.
// ----------------------------------------------------------------------------
module quadratic_root_solver_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = qrs_pkg::COEF_BITS_DEF;
   localparam int FB = qrs_pkg::FRAC_BITS_DEF;
   localparam int RW = qrs_pkg::ROOT_BITS;
   localparam int LATENCY = 2 * CB + FB + 7;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      qrs_pkg::kind_type     kind;
      logic [RW-1:0]         root_one;
      logic [RW-1:0]         root_two;
   } solution_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CB-1:0] req_coef_quad = '0;
   logic signed [CB-1:0] req_coef_lin = '0;
   logic signed [CB-1:0] req_coef_const = '0;
   logic rsp_valid;
   logic [2:0] rsp_solution_kind;
   logic signed [RW-1:0] rsp_root_one;
   logic signed [RW-1:0] rsp_root_two;

   solution_type pending_solutions[$];
   int mismatches = 0;
   int beats_sent = 0;
   int results_seen = 0;
   int kind_hits[6];
   longint cycles = 0;
   bit no_idle = 1'b0;

   quadratic_root_solver dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // truncating fixed point divide with saturation to the root width
   function automatic logic [RW-1:0] fixed_quotient(longint num, longint den);
      longint hi, lo, q;
      hi = (longint'(1) <<< (RW - 1)) - 1;
      lo = -hi - 1;
      q = (num * (longint'(1) <<< FB)) / den;
      if (q > hi) q = hi;
      if (q < lo) q = lo;
      return q[RW-1:0];
   endfunction

   function automatic longint floor_root(longint v);
      longint r;
      r = longint'($sqrt(real'(v)));
      while (r * r > v) r--;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   function automatic solution_type solve_quadratic(logic signed [CB-1:0] qa,
                                                    logic signed [CB-1:0] qb,
                                                    logic signed [CB-1:0] qc);
      solution_type s;
      longint a, b, c, disc, sq;
      a = qa; b = qb; c = qc;
      s = '0;
      if (a == 0 && b == 0) begin
         s.kind = (c == 0) ? qrs_pkg::KIND_INFINITE : qrs_pkg::KIND_NONE;
      end else if (a == 0) begin
         s.kind = qrs_pkg::KIND_LINEAR;
         s.root_one = fixed_quotient(-c, b);
      end else begin
         disc = b * b - 4 * a * c;
         if (disc > 0) begin
            sq = floor_root(disc);
            s.kind = qrs_pkg::KIND_TWO;
            s.root_one = fixed_quotient(-b + sq, 2 * a);
            s.root_two = fixed_quotient(-b - sq, 2 * a);
         end else if (disc == 0) begin
            s.kind = qrs_pkg::KIND_DOUBLE;
            s.root_one = fixed_quotient(-b, 2 * a);
            s.root_two = s.root_one;
         end else begin
            s.kind = qrs_pkg::KIND_COMPLEX;
         end
      end
      return s;
   endfunction

   // random idle burst before a beat, never in the closing stretch
   task automatic idle_gap();
      int n;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 18);
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // one beat: held until the block takes it; start stays high across beats
   task automatic send_coefs(logic signed [CB-1:0] qa, logic signed [CB-1:0] qb,
                             logic signed [CB-1:0] qc);
      idle_gap();
      start <= 1'b1;
      req_coef_quad <= qa;
      req_coef_lin <= qb;
      req_coef_const <= qc;
      do @(posedge clock); while (busy);
      pending_solutions.push_back(solve_quadratic(qa, qb, qc));
      beats_sent++;
      @(negedge clock);
   endtask

   // result checker, sampled on the rising edge
   always @(posedge clock) begin
      solution_type exp_s;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_solutions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
         end else begin
            exp_s = pending_solutions.pop_front();
            if (rsp_solution_kind <= qrs_pkg::KIND_COMPLEX) kind_hits[rsp_solution_kind]++;
            if (rsp_solution_kind !== exp_s.kind || rsp_root_one !== exp_s.root_one
                || rsp_root_two !== exp_s.root_two) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp kind %0d r1 %0d r2 %0d, got kind %0d r1 %0d r2 %0d",
                           exp_s.kind, $signed(exp_s.root_one), $signed(exp_s.root_two),
                           rsp_solution_kind, rsp_root_one, rsp_root_two);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // degenerate equations and the coefficient extremes
   task automatic test_directed();
      logic signed [CB-1:0] mx, mn;
      mx = {1'b0, {(CB-1){1'b1}}};
      mn = {1'b1, {(CB-1){1'b0}}};
      send_coefs(0, 0, 0);         // every x solves
      send_coefs(0, 0, 5);         // no solution
      send_coefs(0, 0, mn);
      send_coefs(0, 3, -7);        // linear
      send_coefs(0, mn, mx);
      send_coefs(0, -1, mn);       // linear root of largest magnitude
      send_coefs(0, mx, mn);
      send_coefs(1, -3, 2);        // two roots
      send_coefs(1, 2, 1);         // double root
      send_coefs(1, 0, 1);         // complex
      send_coefs(mn, mn, mx);      // discriminant at its largest
      send_coefs(mx, mx, mn);
      send_coefs(mn, 0, mn);       // complex at the extremes
      send_coefs(-1, mn, 0);
      send_coefs(mx, mn, 0);
      send_coefs(-4, 4, -1);       // double root, negative leading term
      send_coefs(3, 1, -5);
      send_coefs(-1, -1, -1);
      send_coefs(mn, mn, mn);
      send_coefs(mx, mx, mx);
   endtask

   // mixture of full range values and equations built to hit each case
   task automatic test_random(int count);
      logic signed [CB-1:0] qa, qb, qc;
      int sel, r1, r2, k;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 9);
         qa = CB'($urandom); qb = CB'($urandom); qc = CB'($urandom);
         case (sel)
            0: begin qa = '0; if ($urandom_range(0, 1)) qb = '0; end
            1: begin qa = '0; qb = '0; qc = $urandom_range(0, 1) ? '0 : qc; end
            2: begin
               // double root: k^2 x^2 + 2 k r x + r^2 with small values
               k = $urandom_range(1, 100); r1 = $urandom_range(0, 180) - 90;
               if ($urandom_range(0, 1)) k = -k;
               qa = CB'(k * k); qb = CB'(2 * k * r1); qc = CB'(r1 * r1);
               if ($urandom_range(0, 1)) begin qa = -qa; qb = -qb; qc = -qc; end
            end
            3: begin
               // integer roots: (x - r1)(x - r2) scaled
               r1 = $urandom_range(0, 200) - 100; r2 = $urandom_range(0, 200) - 100;
               k = $urandom_range(1, 3);
               qa = CB'(k); qb = CB'(-k * (r1 + r2)); qc = CB'(k * r1 * r2);
            end
            4: begin
               qa = CB'($urandom_range(0, 30) - 15); qb = CB'($urandom_range(0, 30) - 15);
               qc = CB'($urandom_range(0, 30) - 15);
            end
            default: ;
         endcase
         send_coefs(qa, qb, qc);
      end
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (pending_solutions.size() != 0 && guard < 20 * LATENCY) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1400);
      no_idle = 1'b1;
      test_random(230);
      drain();
      $display("%0d coefficient sets sent, %0d results checked", beats_sent, results_seen);
      $display("kinds seen: inf %0d none %0d lin %0d two %0d dbl %0d cplx %0d",
               kind_hits[qrs_pkg::KIND_INFINITE], kind_hits[qrs_pkg::KIND_NONE],
               kind_hits[qrs_pkg::KIND_LINEAR], kind_hits[qrs_pkg::KIND_TWO],
               kind_hits[qrs_pkg::KIND_DOUBLE], kind_hits[qrs_pkg::KIND_COMPLEX]);
      if (mismatches == 0 && pending_solutions.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
